>>> design/sclru_pkg.sv
package sclru_pkg;

  // Geometry
  localparam int unsigned SETS_DEF = 8;
  localparam int unsigned WAYS     = 4;

  typedef logic [1:0]  action_t;
  typedef logic [1:0]  kind_t;
  typedef logic [31:0] sector_t;
  typedef logic [15:0] order_t;

  // Request codes
  localparam action_t ACT_READ  = 2'd0;
  localparam action_t ACT_WRITE = 2'd1;
  localparam action_t ACT_FLUSH = 2'd2;
  localparam action_t ACT_NONE  = 2'd3;

  // Result codes
  localparam kind_t KIND_ACCESS = 2'd0;
  localparam kind_t KIND_WB     = 2'd1;
  localparam kind_t KIND_DONE   = 2'd2;

  // Marks
  localparam sector_t    EMPTY_TAG   = 32'hFFFF_FFFF;
  localparam order_t     ORDER_RESET = 16'hFFFF;
  localparam logic [3:0] NIB_EMPTY   = 4'hF;

  // One result item as held in the output register
  typedef struct packed {
    kind_t      kind;
    logic       hit;
    logic [3:0] set_index;
    logic [1:0] way_index;
    logic       writeback_needed;
    sector_t    writeback_sector;
    logic       device_read;
    logic       last;
  } res_t;

  // Move a hit way to the most recent slot; the ways after it slide one slot
  // towards least recent. An unmatched way leaves the order alone.
  function automatic order_t order_touch(order_t o, logic [1:0] way);
    logic [3:0] w4;
    order_t     r;
    w4 = {2'b00, way};
    if (o[15:12] == w4)
      r = {o[11:0], o[15:12]};
    else if (o[11:8] == w4)
      r = {o[15:12], o[7:0], o[11:8]};
    else if (o[7:4] == w4)
      r = {o[15:8], o[3:0], o[7:4]};
    else
      r = o;
    return r;
  endfunction

endpackage

>>> design/sclru_if.sv
// Request channel
interface sclru_in_if;
  import sclru_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  sector_t sector;
  modport source (output valid, action, sector, input ready);
  modport sink   (input valid, action, sector, output ready);
endinterface

// Result channel
interface sclru_out_if;
  import sclru_pkg::*;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic       hit;
  logic [3:0] set_index;
  logic [1:0] way_index;
  logic       writeback_needed;
  sector_t    writeback_sector;
  logic       device_read;
  logic       last;
  modport source (output valid, kind, hit, set_index, way_index, writeback_needed,
                  writeback_sector, device_read, last, input ready);
  modport sink   (input valid, kind, hit, set_index, way_index, writeback_needed,
                  writeback_sector, device_read, last, output ready);
endinterface

>>> design/sector_cache_lru_controller_unit.sv
// Tag and replacement controller for a four-way set-associative write-back
// sector cache with least-recently-used eviction.
// Request channel in_ch: action (read, write, flush) and sector. Result
// channel out_ch: one access result per read or write, or for a flush one
// write-back entry per dirty line in set-then-way order and a closing item.
// Both channels transfer when valid and ready are high at a clock edge.
// The block takes one request at a time; in_ch.ready is high only when idle.
// A read or write passes through a hash step, a lookup in which the single
// tag comparator walks the four ways through the one read port of the tag
// memory, a decision step that also reads the victim tag, and an update
// step; the next request can be taken in the same cycle that its result
// becomes valid. A reserved sector answers from a reject step after the hash.
// A flush visits each line, stops at each dirty line to emit its write-back
// entry, then emits the closing item. An unused action code is taken and dropped.
// Results sit in an output register; while the receiver stalls it holds,
// and the sequencer waits at its next result until the register is free.
// Reset (rst_n, synchronous, active low) empties all ways, cleans all dirty
// bits and clears the recency orders at once; no clearing pass is needed.
module sector_cache_lru_controller_unit #(
  parameter int unsigned SETS = sclru_pkg::SETS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  sclru_in_if.sink           in_ch,
  sclru_out_if.source        out_ch
);
  import sclru_pkg::*;

  localparam int unsigned SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned DEPTH = SETS * WAYS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HASH   = 4'd1;
  localparam logic [3:0] S_LOOK   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_UPD    = 4'd4;
  localparam logic [3:0] S_REJECT = 4'd5;
  localparam logic [3:0] S_FSCAN  = 4'd6;
  localparam logic [3:0] S_FEMIT  = 4'd7;
  localparam logic [3:0] S_FDONE  = 4'd8;

  logic [3:0]    state_r, state_nxt;
  sector_t       sector_r, sector_nxt;
  logic          is_write_r, is_write_nxt;
  logic [SW-1:0] set_r, set_nxt;
  logic [1:0]    way_r, way_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          hit_r, hit_nxt;
  logic [1:0]    hit_way_r, hit_way_nxt;
  logic          emp_r, emp_nxt;
  logic [1:0]    emp_way_r, emp_way_nxt;
  logic          vic_dirty_r, vic_dirty_nxt;
  res_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  order_t           order_r [SETS];
  logic [DEPTH-1:0] dirty_r;

  logic          order_we;
  order_t        order_wdata;
  logic          dirty_we;
  logic          dirty_wdata;
  logic          tag_we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] cur_idx;
  sector_t       rd_tag;
  logic [SW-1:0] hash_set;

  logic          out_free;
  order_t        cur_order;
  logic [3:0]    first_nib;
  logic          set_full;
  logic [1:0]    miss_way;
  logic [1:0]    cmp_way;
  logic          at_end;

  sclru_set_hash #(.SETS(SETS), .SW(SW)) u_hash (
    .sector  (sector_r),
    .set_idx (hash_set)
  );

  sclru_tag_store #(.DEPTH(DEPTH), .AW(AW)) u_tags (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .wr_en   (tag_we),
    .wr_addr (cur_idx),
    .wr_data (sector_r)
  );

  // Derived values for the current set
  assign cur_idx   = AW'({set_r, way_r});
  assign cur_order = order_r[set_r];
  assign first_nib = cur_order[15:12];
  assign set_full  = (first_nib != NIB_EMPTY);
  assign miss_way  = set_full ? first_nib[1:0] : (emp_r ? emp_way_r : 2'd0);
  assign cmp_way   = 2'(cnt_r - 3'd1);
  assign at_end    = (way_r == 2'd3) && (set_r == SW'(SETS - 1));
  assign out_free  = !out_valid_r || out_ch.ready;

  // New recency order after an access
  always_comb begin
    if (hit_r)
      order_wdata = order_touch(cur_order, way_r);
    else if (set_full)
      order_wdata = {cur_order[11:0], first_nib};
    else
      order_wdata = {cur_order[11:0], 2'b00, way_r};
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sector_nxt    = sector_r;
    is_write_nxt  = is_write_r;
    set_nxt       = set_r;
    way_nxt       = way_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    hit_way_nxt   = hit_way_r;
    emp_nxt       = emp_r;
    emp_way_nxt   = emp_way_r;
    vic_dirty_nxt = vic_dirty_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rd_en         = 1'b0;
    rd_addr       = cur_idx;
    tag_we        = 1'b0;
    order_we      = 1'b0;
    dirty_we      = 1'b0;
    dirty_wdata   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sector_nxt   = in_ch.sector;
          is_write_nxt = (in_ch.action == ACT_WRITE);
          if (in_ch.action == ACT_FLUSH) begin
            set_nxt   = '0;
            way_nxt   = 2'd0;
            state_nxt = S_FSCAN;
          end else if (in_ch.action == ACT_READ || in_ch.action == ACT_WRITE) begin
            state_nxt = S_HASH;
          end
        end
      end

      S_HASH: begin
        set_nxt = hash_set;
        cnt_nxt = 3'd0;
        hit_nxt = 1'b0;
        emp_nxt = 1'b0;
        state_nxt = (sector_r == EMPTY_TAG) ? S_REJECT : S_LOOK;
      end

      // Read way cnt while comparing the tag of way cnt-1
      S_LOOK: begin
        rd_en   = !cnt_r[2];
        rd_addr = AW'({set_r, cnt_r[1:0]});
        if (cnt_r != 3'd0) begin
          if (!hit_r && rd_tag == sector_r) begin
            hit_nxt     = 1'b1;
            hit_way_nxt = cmp_way;
          end
          if (!emp_r && rd_tag == EMPTY_TAG) begin
            emp_nxt     = 1'b1;
            emp_way_nxt = cmp_way;
          end
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r[2]) state_nxt = S_DECIDE;
      end

      // Pick the way; fetch the victim tag in case it must be written back
      S_DECIDE: begin
        way_nxt       = hit_r ? hit_way_r : miss_way;
        rd_en         = 1'b1;
        rd_addr       = AW'({set_r, miss_way});
        vic_dirty_nxt = set_full && dirty_r[AW'({set_r, miss_way})];
        state_nxt     = S_UPD;
      end

      S_UPD: begin
        if (out_free) begin
          order_we               = 1'b1;
          out_nxt.kind           = KIND_ACCESS;
          out_nxt.hit            = hit_r;
          out_nxt.set_index      = 4'(set_r);
          out_nxt.way_index      = way_r;
          out_nxt.last           = 1'b1;
          if (hit_r) begin
            dirty_we    = is_write_r;
            dirty_wdata = 1'b1;
            out_nxt.writeback_needed = 1'b0;
            out_nxt.writeback_sector = '0;
            out_nxt.device_read      = 1'b0;
          end else begin
            tag_we      = 1'b1;
            dirty_we    = 1'b1;
            dirty_wdata = is_write_r;
            out_nxt.writeback_needed = vic_dirty_r;
            out_nxt.writeback_sector = vic_dirty_r ? rd_tag : '0;
            out_nxt.device_read      = !is_write_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Reserved sector: answer without touching state
      S_REJECT: begin
        if (out_free) begin
          out_nxt.kind             = KIND_ACCESS;
          out_nxt.hit              = 1'b0;
          out_nxt.set_index        = 4'(set_r);
          out_nxt.way_index        = 2'd0;
          out_nxt.writeback_needed = 1'b0;
          out_nxt.writeback_sector = '0;
          out_nxt.device_read      = 1'b0;
          out_nxt.last             = 1'b1;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      // Flush walk: one line a cycle, stop to report a dirty one
      S_FSCAN: begin
        if (dirty_r[cur_idx]) begin
          rd_en     = 1'b1;
          state_nxt = S_FEMIT;
        end else begin
          way_nxt = way_r + 2'd1;
          if (way_r == 2'd3) set_nxt = set_r + SW'(1);
          if (at_end) state_nxt = S_FDONE;
        end
      end

      S_FEMIT: begin
        if (out_free) begin
          dirty_we                 = 1'b1;
          dirty_wdata              = 1'b0;
          out_nxt.kind             = KIND_WB;
          out_nxt.hit              = 1'b0;
          out_nxt.set_index        = 4'(set_r);
          out_nxt.way_index        = way_r;
          out_nxt.writeback_needed = 1'b1;
          out_nxt.writeback_sector = rd_tag;
          out_nxt.device_read      = 1'b0;
          out_nxt.last             = 1'b0;
          out_valid_nxt            = 1'b1;
          way_nxt = way_r + 2'd1;
          if (way_r == 2'd3) set_nxt = set_r + SW'(1);
          state_nxt = at_end ? S_FDONE : S_FSCAN;
        end
      end

      S_FDONE: begin
        if (out_free) begin
          out_nxt.kind             = KIND_DONE;
          out_nxt.hit              = 1'b0;
          out_nxt.set_index        = 4'd0;
          out_nxt.way_index        = 2'd0;
          out_nxt.writeback_needed = 1'b0;
          out_nxt.writeback_sector = '0;
          out_nxt.device_read      = 1'b0;
          out_nxt.last             = 1'b1;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    sector_r    <= sector_nxt;
    is_write_r  <= is_write_nxt;
    set_r       <= set_nxt;
    way_r       <= way_nxt;
    cnt_r       <= cnt_nxt;
    hit_r       <= hit_nxt;
    hit_way_r   <= hit_way_nxt;
    emp_r       <= emp_nxt;
    emp_way_r   <= emp_way_nxt;
    vic_dirty_r <= vic_dirty_nxt;
    out_r       <= out_nxt;
  end

  // Recency orders
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SETS; i++) order_r[i] <= ORDER_RESET;
    end else if (order_we) begin
      order_r[set_r] <= order_wdata;
    end
  end

  // Dirty bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= '0;
    end else if (dirty_we) begin
      dirty_r[cur_idx] <= dirty_wdata;
    end
  end

  // Port drive
  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = out_r.kind;
  assign out_ch.hit              = out_r.hit;
  assign out_ch.set_index        = out_r.set_index;
  assign out_ch.way_index        = out_r.way_index;
  assign out_ch.writeback_needed = out_r.writeback_needed;
  assign out_ch.writeback_sector = out_r.writeback_sector;
  assign out_ch.device_read      = out_r.device_read;
  assign out_ch.last             = out_r.last;

endmodule

>>> design/sclru_set_hash.sv
// Byte-fold hash of a sector, reduced modulo the set count by multiplying
// with a scaled reciprocal of the set count. With a 12-bit scale the
// quotient is exact for every 8-bit hash and any set count up to 15.
module sclru_set_hash #(
  parameter int unsigned SETS = 8,
  parameter int unsigned SW   = 3
) (
  input  sclru_pkg::sector_t sector,
  output logic [SW-1:0]      set_idx
);
  import sclru_pkg::*;

  localparam logic [12:0] RCP = 13'((4096 + SETS - 1) / SETS);
  localparam logic [7:0]  DIV = 8'(SETS);

  logic [7:0]  hash;
  logic [19:0] prod;
  logic [7:0]  quot;
  logic [7:0]  back;
  logic [7:0]  rem;

  assign hash = sector[31:24] ^ sector[23:16] ^ sector[15:8] ^ sector[7:0];

  // Quotient by reciprocal, then remainder by one multiply and subtract
  assign prod = 20'(hash) * 20'(RCP);
  assign quot = prod[19:12];
  assign back = quot * DIV;
  assign rem  = hash - back;

  assign set_idx = rem[SW-1:0];

endmodule

>>> design/sclru_tag_store.sv
// Tag memory: one write and one read port, registered read. An entry never
// written reads back as the empty mark through its valid bit.
module sclru_tag_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output sclru_pkg::sector_t rd_tag,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  sclru_pkg::sector_t wr_data
);
  import sclru_pkg::*;

  sector_t          mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  sector_t          rd_data_r;
  logic             rd_vld_r;

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_tag = rd_vld_r ? rd_data_r : EMPTY_TAG;

endmodule

>>> design/sclru_checker.sv
// Port-level checks on the controller
module sclru_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_writeback_sector,
  input logic        out_last
);
  import sclru_pkg::*;

  // A real request keeps the block busy in the following cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action != ACT_NONE |=> !in_ready)
    else $error("request taken while previous one in progress");

  // An unused action code is dropped at once
  a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_NONE |=> in_ready)
    else $error("unused action code held the block");

  // Once idle, any result still waiting is the final one of its request
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("block idle with a non-final result pending");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_writeback_sector) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind sector_cache_lru_controller_unit sclru_checker u_sclru_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .in_action            (in_ch.action),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_kind             (out_ch.kind),
  .out_writeback_sector (out_ch.writeback_sector),
  .out_last             (out_ch.last)
);
